// ----- rtl/srrip_pkg.sv -----
`default_nettype none
package srrip_pkg;

  localparam int unsigned SETS_DEF           = 2048;
  localparam int unsigned WAYS_DEF           = 16;
  localparam int unsigned HISTORY_LENGTH_DEF = 4;
  localparam int unsigned TABLE_ENTRIES_DEF  = 128;
  localparam int unsigned SIGNATURE_BITS_DEF = 5;

  localparam int unsigned SET_W   = 11;
  localparam int unsigned WAY_W   = 4;
  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned PC_W    = 7;
  localparam int unsigned DELTA_W = 32;
  localparam int unsigned CFG_W   = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned RRPV_W = 2;
  localparam logic [RRPV_W-1:0] RRPV_TOP = 2'((1 << RRPV_W) - 1);
  localparam int unsigned CTR_BITS = 2;
  localparam logic [CTR_BITS-1:0] CTR_MAX   = 2'((1 << CTR_BITS) - 1);
  localparam logic [CTR_BITS-1:0] CTR_MID   = 2'((1 << CTR_BITS) / 2);
  localparam logic [CTR_BITS-1:0] CTR_RESET = 2'd1;
  localparam logic [PC_W-1:0] SIG_STORE_MASK = 7'h1f;

  localparam logic CMD_QUERY  = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAVORED   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISTANT   = 2'd2;

  localparam logic [2:0] THRESHOLD_RST = 3'd3;
  localparam logic [1:0] FAVORED_RST   = 2'd1;
  localparam logic [1:0] DISTANT_RST   = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  // reduce modulo a constant by conditional subtraction
  function automatic logic [15:0] mod_red(input logic [15:0] v, input int unsigned m);
    logic [31:0] r;
    r = {16'b0, v};
    for (int k = 15; k >= 0; k--) begin
      if (r >= (32'(m) << k)) begin
        r = r - (32'(m) << k);
      end
    end
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/srrip_age.sv -----
`default_nettype none
module srrip_age import srrip_pkg::*; #(
  parameter int unsigned WAYS = WAYS_DEF
) (
  input  wire logic [WAYS*RRPV_W-1:0] row_i,
  output logic      [WAYS*RRPV_W-1:0] aged_o,
  output logic      [$clog2(WAYS)-1:0] victim_o
);

  localparam int unsigned WW = $clog2(WAYS);

  logic [RRPV_W-1:0] mx;
  logic [RRPV_W-1:0] step;
  logic [WAYS-1:0] hit_max;

  always_comb begin
    mx = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (row_i[i*RRPV_W +: RRPV_W] > mx) begin
        mx = row_i[i*RRPV_W +: RRPV_W];
      end
    end
    step = RRPV_TOP - mx;
    for (int i = 0; i < WAYS; i++) begin
      aged_o[i*RRPV_W +: RRPV_W] = row_i[i*RRPV_W +: RRPV_W] + step;
      hit_max[i] = (row_i[i*RRPV_W +: RRPV_W] == mx);
    end
    victim_o = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (hit_max[i]) begin
        victim_o = WW'(i);
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/srrip_det.sv -----
`default_nettype none
module srrip_det import srrip_pkg::*; #(
  parameter int unsigned HISTORY_LENGTH = HISTORY_LENGTH_DEF
) (
  input  wire logic [ADDR_W-1:0]                 last_i,
  input  wire logic [HISTORY_LENGTH*DELTA_W-1:0] hist_i,
  input  wire logic [$clog2(HISTORY_LENGTH)-1:0] ptr_i,
  input  wire logic                              strm_i,
  input  wire logic [ADDR_W-1:0]                 addr_i,
  input  wire logic [CFG_W-1:0]                  thr_i,
  output logic      [ADDR_W-1:0]                 last_o,
  output logic      [HISTORY_LENGTH*DELTA_W-1:0] hist_o,
  output logic      [$clog2(HISTORY_LENGTH)-1:0] ptr_o,
  output logic                                   strm_o
);

  localparam int unsigned PW = $clog2(HISTORY_LENGTH);
  localparam int unsigned CNT_W = $clog2(HISTORY_LENGTH + 1);

  logic [DELTA_W-1:0] delta;
  logic [ADDR_W-1:0] diff;
  logic [HISTORY_LENGTH*DELTA_W-1:0] hist_new;
  logic [HISTORY_LENGTH-1:0] match;
  logic [CNT_W-1:0] cnt;

  always_comb begin
    diff = addr_i - last_i;
    delta = diff[DELTA_W-1:0];
    hist_new = hist_i;
    hist_new[ptr_i*DELTA_W +: DELTA_W] = delta;
    for (int i = 0; i < HISTORY_LENGTH; i++) begin
      match[i] = (hist_new[i*DELTA_W +: DELTA_W] == delta);
    end
    cnt = CNT_W'($countones(match));
    last_o = addr_i;
    if (last_i != '0) begin
      hist_o = hist_new;
      ptr_o  = (ptr_i == PW'(HISTORY_LENGTH - 1)) ? '0 : ptr_i + 1'b1;
      strm_o = (32'(cnt) >= 32'(thr_i));
    end else begin
      hist_o = hist_i;
      ptr_o  = ptr_i;
      strm_o = strm_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ship_rrip_stream_bypass_replacement_unit.sv -----
// Flow: an accepted beat reads the per-set memories, then modifies and writes back in EXEC;
// a query's victim is registered into the output register at that write-back, and a query
// waits in EXEC while an earlier result is stalled. No new beat is taken until write-back.
// Reset: a clearing pass sweeps every set of the per-set memories; no beat is taken meanwhile.
// Reuse counters reset at once through per-entry valid bits.
`default_nettype none
module ship_rrip_stream_bypass_replacement_unit import srrip_pkg::*; #(
  parameter int unsigned SETS           = SETS_DEF,
  parameter int unsigned WAYS           = WAYS_DEF,
  parameter int unsigned HISTORY_LENGTH = HISTORY_LENGTH_DEF,
  parameter int unsigned TABLE_ENTRIES  = TABLE_ENTRIES_DEF,
  parameter int unsigned SIGNATURE_BITS = SIGNATURE_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 command_i,
  input  wire logic [SET_W-1:0]     set_index_i,
  input  wire logic [WAY_W-1:0]     way_index_i,
  input  wire logic [ADDR_W-1:0]    access_address_i,
  input  wire logic [PC_W-1:0]      pc_hash_i,
  input  wire logic                 was_hit_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [WAY_W-1:0]     victim_way_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned SW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WW = $clog2(WAYS);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES);
  localparam int unsigned PW = $clog2(HISTORY_LENGTH);
  localparam int unsigned RW = WAYS * RRPV_W;
  localparam int unsigned HW = HISTORY_LENGTH * DELTA_W;
  localparam int unsigned DW = ADDR_W + HW + PW + 1;
  localparam logic [PC_W-1:0] SIG_MASK =
      PC_W'(((1 << SIGNATURE_BITS) - 1) & 32'(SIG_STORE_MASK));

  logic [RW-1:0] rrpv_mem [SETS];
  logic [DW-1:0] det_mem [SETS];
  logic [CTR_BITS-1:0] ctr_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] ctr_vld_q;

  state_e st_q, st_d;
  logic [SW-1:0] clr_q, clr_d;
  logic [CFG_W-1:0] thr_q;
  logic [1:0] fav_q, dist_q;

  logic cmd_q, hit_q;
  logic [SW-1:0] set_q;
  logic [WW-1:0] way_q;
  logic [ADDR_W-1:0] addr_q;
  logic [CW-1:0] tidx_q, eidx_q;
  logic [RW-1:0] row_q;
  logic [DW-1:0] det_q;
  logic [CTR_BITS-1:0] ca_q, cb_q;
  logic va_q, vb_q;
  logic out_valid_q, out_valid_d;
  logic [WAY_W-1:0] victim_q;

  logic accept, done, in_clear;
  logic [SW-1:0] set_in;
  logic [CW-1:0] tidx_in, eidx_in;
  logic [RW-1:0] aged, new_row, row_wdata;
  logic [WW-1:0] vic;
  logic [ADDR_W-1:0] last_n;
  logic [HW-1:0] hist_n;
  logic [PW-1:0] ptr_n;
  logic strm_n;
  logic [CTR_BITS-1:0] ca, cb;
  logic [RRPV_W-1:0] ins;
  logic ctr_we;
  logic [CW-1:0] ctr_waddr;
  logic [CTR_BITS-1:0] ctr_wdata;

  assign in_clear   = (st_q == ST_CLEAR);
  assign in_ready_o = (st_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign done       = (st_q == ST_EXEC) &&
                      ((cmd_q == CMD_UPDATE) || !out_valid_q || out_ready_i);
  assign set_in     = SW'(mod_red(16'(set_index_i), SETS));
  assign tidx_in    = CW'(mod_red(16'(pc_hash_i), TABLE_ENTRIES));
  assign eidx_in    = CW'(pc_hash_i & SIG_MASK);

  srrip_age #(.WAYS(WAYS)) u_age (
    .row_i    (row_q),
    .aged_o   (aged),
    .victim_o (vic)
  );

  srrip_det #(.HISTORY_LENGTH(HISTORY_LENGTH)) u_det (
    .last_i (det_q[DW-1 -: ADDR_W]),
    .hist_i (det_q[PW+1 +: HW]),
    .ptr_i  (det_q[1 +: PW]),
    .strm_i (det_q[0]),
    .addr_i (addr_q),
    .thr_i  (thr_q),
    .last_o (last_n),
    .hist_o (hist_n),
    .ptr_o  (ptr_n),
    .strm_o (strm_n)
  );

  always_comb begin
    ca = va_q ? ca_q : CTR_RESET;
    cb = vb_q ? cb_q : CTR_RESET;
    if (strm_n) begin
      ins = RRPV_TOP;
    end else if (ca >= CTR_MID) begin
      ins = fav_q;
    end else begin
      ins = dist_q;
    end
    new_row = row_q;
    new_row[way_q*RRPV_W +: RRPV_W] = hit_q ? '0 : ins;
    row_wdata = (cmd_q == CMD_QUERY) ? aged : new_row;
    ctr_we = 1'b0;
    ctr_waddr = tidx_q;
    ctr_wdata = ca;
    if (done && (cmd_q == CMD_UPDATE)) begin
      if (hit_q) begin
        ctr_we = 1'b1;
        ctr_wdata = (ca == CTR_MAX) ? ca : ca + 1'b1;
      end else if (ins == RRPV_TOP) begin
        ctr_we = 1'b1;
        ctr_waddr = eidx_q;
        ctr_wdata = (cb == '0) ? cb : cb - 1'b1;
      end
    end
  end

  always_comb begin
    st_d = st_q;
    clr_d = clr_q;
    unique case (st_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == SW'(SETS - 1)) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          st_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (done) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_CLEAR;
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || (done && (cmd_q == CMD_QUERY));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      ctr_vld_q   <= '0;
      thr_q       <= THRESHOLD_RST;
      fav_q       <= FAVORED_RST;
      dist_q      <= DISTANT_RST;
    end else begin
      st_q        <= st_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (ctr_we) begin
        ctr_vld_q[ctr_waddr] <= 1'b1;
      end
      if (cfg_we_i) begin
        priority case (cfg_index_i)
          CFG_THRESHOLD: thr_q  <= cfg_data_i;
          CFG_FAVORED:   fav_q  <= cfg_data_i[1:0];
          CFG_DISTANT:   dist_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= command_i;
      hit_q  <= was_hit_i;
      set_q  <= set_in;
      way_q  <= WW'(mod_red(16'(way_index_i), WAYS));
      addr_q <= access_address_i;
      tidx_q <= tidx_in;
      eidx_q <= eidx_in;
      row_q  <= rrpv_mem[set_in];
      det_q  <= det_mem[set_in];
      ca_q   <= ctr_mem[tidx_in];
      cb_q   <= ctr_mem[eidx_in];
      va_q   <= ctr_vld_q[tidx_in];
      vb_q   <= ctr_vld_q[eidx_in];
    end
    if (done && (cmd_q == CMD_QUERY)) begin
      victim_q <= WAY_W'(vic);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_clear) begin
      rrpv_mem[clr_q] <= {WAYS{RRPV_TOP}};
      det_mem[clr_q]  <= '0;
    end else if (done) begin
      rrpv_mem[set_q] <= row_wdata;
      if (cmd_q == CMD_UPDATE) begin
        det_mem[set_q] <= {last_n, hist_n, ptr_n, strm_n};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctr_we) begin
      ctr_mem[ctr_waddr] <= ctr_wdata;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign victim_way_o = victim_q;

endmodule
`default_nettype wire

// ----- rtl/srrip_checker.sv -----
`default_nettype none
module srrip_checker import srrip_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             command_i,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [WAY_W-1:0] victim_way_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(victim_way_o)))
    else $error("result beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second beat taken while one is in flight");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && (command_i == CMD_QUERY), 2))
    else $error("result beat without a query two cycles earlier");

  a_update_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (command_i == CMD_UPDATE)) |-> ##2 !$rose(out_valid_o))
    else $error("update produced a result beat");

endmodule

bind ship_rrip_stream_bypass_replacement_unit srrip_checker u_srrip_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .command_i    (command_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .victim_way_o (victim_way_o)
);
`default_nettype wire
